// ----- rtl/core/lcsc_pkg.sv -----
package lcsc_pkg;

  // Light averaging window; must be a power of two (average is a shift).
  localparam int unsigned SAMPLE_COUNT = 8;
  localparam int unsigned SampleShift  = $clog2(SAMPLE_COUNT);
  localparam int unsigned IdxW         = (SampleShift > 0) ? SampleShift : 1;

  localparam int unsigned LightW = 12;
  localparam int unsigned SumW   = LightW + SampleShift;
  localparam int unsigned TempW  = 15;
  localparam int unsigned HumW   = 14;
  localparam int unsigned StepW  = 7;
  localparam int unsigned AngleW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [HumW-1:0] HumMax = HumW'(10000);

  typedef enum logic [1:0] {
    KIND_LIGHT   = 2'd0,
    KIND_CLIMATE = 2'd1,
    KIND_MODE    = 2'd2,
    KIND_TICK    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_AUTO  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OPEN_THR  = 3'd0,
    REG_CLOSE_THR = 3'd1,
    REG_HOT_LIM   = 3'd2,
    REG_HUMID_LIM = 3'd3,
    REG_STEP      = 3'd4,
    REG_MAX_ANGLE = 3'd5,
    REG_MIN_ANGLE = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [LightW-1:0]       open_thr;
    logic [LightW-1:0]       close_thr;
    logic signed [TempW-1:0] hot_limit;
    logic [HumW-1:0]         humid_limit;
    logic [StepW-1:0]        step_size;
    logic [AngleW-1:0]       max_angle;
    logic [AngleW-1:0]       min_angle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [LightW-1:0]       light_sample;
    logic                    read_ok;
    logic signed [TempW-1:0] temp_reading;
    logic [HumW-1:0]         hum_reading;
    logic [1:0]              mode_cmd;
  } item_t;

  typedef struct packed {
    logic [AngleW-1:0] servo_angle;
    logic              bright_flag;
    logic [1:0]        mode_now;
    logic              climate_valid;
    logic              reading_rejected;
  } result_t;

endpackage

// ----- rtl/core/lcsc_cfg_regs.sv -----
module lcsc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [lcsc_pkg::CfgIdxW-1:0]     wr_idx_i,
  input  logic [lcsc_pkg::CfgDataW-1:0]    wr_data_i,
  output lcsc_pkg::cfg_t                   cfg_o
);
  import lcsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_OPEN_THR:  cfg_d.open_thr    = wr_data_i[LightW-1:0];
        REG_CLOSE_THR: cfg_d.close_thr   = wr_data_i[LightW-1:0];
        REG_HOT_LIM:   cfg_d.hot_limit   = $signed(wr_data_i[TempW-1:0]);
        REG_HUMID_LIM: cfg_d.humid_limit = wr_data_i[HumW-1:0];
        REG_STEP:      cfg_d.step_size   = wr_data_i[StepW-1:0];
        REG_MAX_ANGLE: cfg_d.max_angle   = wr_data_i[AngleW-1:0];
        REG_MIN_ANGLE: cfg_d.min_angle   = wr_data_i[AngleW-1:0];
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_thr    <= LightW'(2500);
      cfg_q.close_thr   <= LightW'(2000);
      cfg_q.hot_limit   <= TempW'(3000);
      cfg_q.humid_limit <= HumW'(8000);
      cfg_q.step_size   <= StepW'(5);
      cfg_q.max_angle   <= AngleW'(90);
      cfg_q.min_angle   <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/lcsc_core.sv -----
module lcsc_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  lcsc_pkg::item_t    item_i,
  input  lcsc_pkg::cfg_t     cfg_i,
  output lcsc_pkg::result_t  result_o
);
  import lcsc_pkg::*;

  logic [SumW-1:0]         sum_q, sum_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    bright_q, bright_d;
  mode_e                   mode_q, mode_d;
  logic [AngleW-1:0]       pos_q, pos_d;
  logic                    good_q, good_d;
  logic signed [TempW-1:0] temp_q, temp_d;
  logic [HumW-1:0]         hum_q, hum_d;
  logic                    rejected;

  logic [SumW-1:0]         sum_add;
  logic [LightW-1:0]       avg;
  logic                    win_done;
  logic                    set_b;
  logic                    harsh;
  logic [AngleW-1:0]       target;
  logic [AngleW:0]         up_pos;
  logic signed [AngleW+1:0] dn_pos;
  logic [AngleW-1:0]       moved;

  assign sum_add  = sum_q + SumW'(item_i.light_sample);
  assign avg      = sum_add[SumW-1 -: LightW];
  assign win_done = (SampleShift == 0) || (idx_q == IdxW'(SAMPLE_COUNT - 1));
  assign set_b    = bright_q | (avg >= cfg_i.open_thr);

  assign harsh = good_q && ((temp_q >= cfg_i.hot_limit) || (hum_q >= cfg_i.humid_limit));

  always_comb begin
    case (mode_q)
      MODE_OPEN:  target = cfg_i.max_angle;
      MODE_CLOSE: target = cfg_i.min_angle;
      default:    target = (bright_q && !harsh) ? cfg_i.max_angle : cfg_i.min_angle;
    endcase
  end

  assign up_pos = {1'b0, pos_q} + (AngleW+1)'(cfg_i.step_size);
  assign dn_pos = $signed({2'b00, pos_q}) - $signed((AngleW+2)'(cfg_i.step_size));

  always_comb begin
    moved = pos_q;
    if (target > pos_q) begin
      moved = (up_pos < {1'b0, target}) ? up_pos[AngleW-1:0] : target;
    end else if (target < pos_q) begin
      moved = (dn_pos > $signed({2'b00, target})) ? dn_pos[AngleW-1:0] : target;
    end
  end

  always_comb begin
    sum_d    = sum_q;
    idx_d    = idx_q;
    bright_d = bright_q;
    mode_d   = mode_q;
    pos_d    = pos_q;
    good_d   = good_q;
    temp_d   = temp_q;
    hum_d    = hum_q;
    rejected = 1'b0;
    unique case (kind_e'(item_i.kind))
      KIND_LIGHT: begin
        if (win_done) begin
          // set test first, then clear test on the same average
          bright_d = set_b & ~(avg <= cfg_i.close_thr);
          sum_d    = '0;
          idx_d    = '0;
        end else begin
          sum_d = sum_add;
          idx_d = idx_q + IdxW'(1);
        end
      end
      KIND_CLIMATE: begin
        if (!item_i.read_ok || (item_i.hum_reading > HumMax) ||
            (item_i.temp_reading == '0 && item_i.hum_reading == '0)) begin
          rejected = 1'b1;
        end else begin
          temp_d = item_i.temp_reading;
          hum_d  = item_i.hum_reading;
          good_d = 1'b1;
        end
      end
      KIND_MODE: begin
        case (item_i.mode_cmd) inside
          MODE_OPEN, MODE_CLOSE, MODE_AUTO: mode_d = mode_e'(item_i.mode_cmd);
          default: ;  // reserved command keeps mode
        endcase
      end
      KIND_TICK: begin
        if (moved < cfg_i.min_angle)      pos_d = cfg_i.min_angle;
        else if (moved > cfg_i.max_angle) pos_d = cfg_i.max_angle;
        else                              pos_d = moved;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      idx_q    <= '0;
      bright_q <= 1'b0;
      mode_q   <= MODE_AUTO;
      pos_q    <= '0;
      good_q   <= 1'b0;
      temp_q   <= '0;
      hum_q    <= '0;
    end else if (fire_i) begin
      sum_q    <= sum_d;
      idx_q    <= idx_d;
      bright_q <= bright_d;
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      good_q   <= good_d;
      temp_q   <= temp_d;
      hum_q    <= hum_d;
    end
  end

  assign result_o.servo_angle      = pos_d;
  assign result_o.bright_flag      = bright_d;
  assign result_o.mode_now         = mode_d;
  assign result_o.climate_valid    = good_d;
  assign result_o.reading_rejected = rejected;

endmodule

// ----- rtl/core/light_climate_servo_controller_unit.sv -----
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-----------------------------------------
// in       | input     | in_valid_i/in_ready_o   | kind, light_sample, read_ok, temp, hum, mode_cmd
// out      | output    | out_valid_o/out_ready_i | servo_angle, bright_flag, mode_now, flags
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle sustained while out_ready_i stays high; the result is valid once the item
// has passed the input register, then the state update into the output register.
// The state update for an item is one pass of compare/add/clamp logic in lcsc_core.
// Reset (async, active low) empties both stages and loads the default settings.
// A stalled output holds the item in the input register; in_ready_o then drops.
module light_climate_servo_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [lcsc_pkg::LightW-1:0]   light_sample_i,
  input  logic                          read_ok_i,
  input  logic signed [lcsc_pkg::TempW-1:0] temp_reading_i,
  input  logic [lcsc_pkg::HumW-1:0]     hum_reading_i,
  input  logic [1:0]                    mode_cmd_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lcsc_pkg::AngleW-1:0]   servo_angle_o,
  output logic                          bright_flag_o,
  output logic [1:0]                    mode_now_o,
  output logic                          climate_valid_o,
  output logic                          reading_rejected_o,
  // settings write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lcsc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lcsc_pkg::CfgDataW-1:0] cfg_data_i
);
  import lcsc_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  result_t res_d, res_q;
  logic    res_vld_q;
  logic    advance;   // output stage can take the next result
  logic    fire;      // item in input register gets processed this cycle
  logic    in_take;

  // settings are always writable
  assign cfg_ready_o = 1'b1;

  lcsc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign advance    = !res_vld_q || out_ready_i;
  assign fire       = item_vld_q && advance;
  assign in_ready_o = !item_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      item_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind         <= kind_i;
      item_q.light_sample <= light_sample_i;
      item_q.read_ok      <= read_ok_i;
      item_q.temp_reading <= temp_reading_i;
      item_q.hum_reading  <= hum_reading_i;
      item_q.mode_cmd     <= mode_cmd_i;
    end
  end

  // state update and result
  lcsc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (res_d)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = res_vld_q;
  assign servo_angle_o      = res_q.servo_angle;
  assign bright_flag_o      = res_q.bright_flag;
  assign mode_now_o         = res_q.mode_now;
  assign climate_valid_o    = res_q.climate_valid;
  assign reading_rejected_o = res_q.reading_rejected;

endmodule
